>>> rtl/four_pass_height_smoothing_defines.svh
// Assertion macros used by the smoothing walk (fphs_walk).
`ifndef FOUR_PASS_HEIGHT_SMOOTHING_DEFINES_SVH
`define FOUR_PASS_HEIGHT_SMOOTHING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPHS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fphs_pkg.sv
package fphs_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int SIDE_W      = $clog2(MAX_SIDE);
   localparam int ADDR_W      = 2 * SIDE_W;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int HEIGHT_W    = 32;
   localparam int COEFF_W     = 17;
   localparam int GRID_W      = 7;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 4;

   localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(65536);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_FILTER = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COEFF = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE  = CSR_IDX_W'(1);

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   waddr;
      logic [HEIGHT_W-1:0] wdata;
      logic                re;
      logic [ADDR_W-1:0]   raddr;
   } mem_req_type;

endpackage

>>> rtl/fphs_store.sv
module fphs_store (
   input  logic                          clock,
   input  fphs_pkg::mem_req_type         mem_req,
   output logic [fphs_pkg::HEIGHT_W-1:0] rd_data
);
   import fphs_pkg::*;

   logic [HEIGHT_W-1:0] mem [STORE_DEPTH];
   logic [HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fphs_blend.sv
module fphs_blend (
   input  logic                          clock,
   input  logic                          load,
   input  logic [fphs_pkg::HEIGHT_W-1:0] prev,
   input  logic [fphs_pkg::HEIGHT_W-1:0] cur,
   input  logic [fphs_pkg::COEFF_W-1:0]  coeff,
   output logic [fphs_pkg::HEIGHT_W-1:0] result
);
   import fphs_pkg::*;

   localparam int DIFF_W = HEIGHT_W + 1;
   localparam int PROD_W = COEFF_W + 1 + DIFF_W;
   localparam int FRAC_W = 16;
   localparam int SUM_W  = PROD_W - FRAC_W;

   // k*prev + (1-k)*cur is rewritten as cur + k*(prev-cur), one multiply.
   logic signed [DIFF_W-1:0]  diff;
   logic signed [COEFF_W:0]   coeff_s;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [HEIGHT_W-1:0] cur_ff;
   logic signed [SUM_W-1:0]   sum;

   assign diff    = DIFF_W'($signed(prev)) - DIFF_W'($signed(cur));
   assign coeff_s = $signed({1'b0, coeff});
   assign prod_in = coeff_s * diff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         cur_ff  <= $signed(cur);
      end
   end

   // The arithmetic shift floors the product; the sum stays between prev and cur.
   assign sum    = SUM_W'(cur_ff) + prod_ff[PROD_W-1:FRAC_W];
   assign result = sum[HEIGHT_W-1:0];

endmodule

>>> rtl/fphs_walk.sv
`include "four_pass_height_smoothing_defines.svh"

module fphs_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fphs_pkg::COEFF_W-1:0]  coeff_cfg,
   input  logic [fphs_pkg::GRID_W-1:0]   side_cfg,
   input  logic [fphs_pkg::HEIGHT_W-1:0] rd_data,
   input  logic                          fin_ack,
   output fphs_pkg::mem_req_type         walk_mem,
   output logic                          busy,
   output logic                          fin_req
);
   import fphs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_HEAD  = 7'b0000010,
      S_PRIME = 7'b0000100,
      S_FETCH = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_STORE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      PASS_EAST  = 2'd0,
      PASS_WEST  = 2'd1,
      PASS_SOUTH = 2'd2,
      PASS_NORTH = 2'd3
   } pass_type;

   state_type           state_ff, state_in;
   pass_type            pass_ff, pass_in;
   logic [SIDE_W-1:0]   band_ff, band_in;
   logic [SIDE_W-1:0]   pos_ff, pos_in;
   logic [SIDE_W-1:0]   side_m1_ff, side_m1_in;
   logic [COEFF_W-1:0]  coeff_ff, coeff_in;
   logic [HEIGHT_W-1:0] prev_ff, prev_in;

   logic [COEFF_W-1:0]  coeff_eff;
   logic [GRID_W-1:0]   side_eff;
   logic [SIDE_W-1:0]   rev_pos;
   logic [SIDE_W-1:0]   row;
   logic [SIDE_W-1:0]   col;
   logic [GRID_W-1:0]   side_n;
   logic [2*SIDE_W:0]   lin;
   logic [ADDR_W-1:0]   addr;
   logic                blend_load;
   logic [HEIGHT_W-1:0] blend_res;

   assign coeff_eff = (coeff_cfg > COEFF_ONE) ? COEFF_ONE : coeff_cfg;
   assign side_eff  = (side_cfg > GRID_W'(MAX_SIDE)) ? GRID_W'(MAX_SIDE) : side_cfg;

   // Cell address of position pos_ff in band band_ff of the current pass.
   assign rev_pos = side_m1_ff - pos_ff;
   always_comb begin
      unique case (pass_ff)
         PASS_EAST: begin
            row = band_ff;
            col = pos_ff;
         end
         PASS_WEST: begin
            row = band_ff;
            col = rev_pos;
         end
         PASS_SOUTH: begin
            row = pos_ff;
            col = band_ff;
         end
         PASS_NORTH: begin
            row = rev_pos;
            col = band_ff;
         end
         default: begin
            row = band_ff;
            col = pos_ff;
         end
      endcase
   end

   assign side_n = GRID_W'(side_m1_ff) + GRID_W'(1);
   assign lin    = row * side_n + (2*SIDE_W+1)'(col);
   assign addr   = lin[ADDR_W-1:0];

   assign blend_load = (state_ff == S_MUL);

   fphs_blend u_blend (
      .clock  (clock),
      .load   (blend_load),
      .prev   (prev_ff),
      .cur    (rd_data),
      .coeff  (coeff_ff),
      .result (blend_res)
   );

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      band_in    = band_ff;
      pos_in     = pos_ff;
      side_m1_in = side_m1_ff;
      coeff_in   = coeff_ff;
      prev_in    = prev_ff;
      walk_mem   = '0;
      walk_mem.raddr = addr;
      walk_mem.waddr = addr;
      walk_mem.wdata = blend_res;
      fin_req    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pass_in    = PASS_EAST;
               band_in    = '0;
               pos_in     = '0;
               coeff_in   = coeff_eff;
               side_m1_in = SIDE_W'(side_eff - GRID_W'(1));
               // A side of zero or one leaves every band with its first cell only.
               state_in   = (side_cfg < GRID_W'(2)) ? S_DONE : S_HEAD;
            end
         end
         S_HEAD: begin
            walk_mem.re = 1'b1;
            state_in    = S_PRIME;
         end
         S_PRIME: begin
            prev_in  = rd_data;
            pos_in   = pos_ff + SIDE_W'(1);
            state_in = S_FETCH;
         end
         S_FETCH: begin
            walk_mem.re = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            state_in = S_STORE;
         end
         S_STORE: begin
            walk_mem.we = 1'b1;
            prev_in     = blend_res;
            if (pos_ff == side_m1_ff) begin
               pos_in = '0;
               if (band_ff == side_m1_ff) begin
                  band_in = '0;
                  if (pass_ff == PASS_NORTH) begin
                     state_in = S_DONE;
                  end else begin
                     pass_in  = pass_type'(pass_ff + 2'd1);
                     state_in = S_HEAD;
                  end
               end else begin
                  band_in  = band_ff + SIDE_W'(1);
                  state_in = S_HEAD;
               end
            end else begin
               pos_in   = pos_ff + SIDE_W'(1);
               state_in = S_FETCH;
            end
         end
         S_DONE: begin
            fin_req = 1'b1;
            if (fin_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pass_ff    <= PASS_EAST;
         band_ff    <= '0;
         pos_ff     <= '0;
         side_m1_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         band_ff    <= band_in;
         pos_ff     <= pos_in;
         side_m1_ff <= side_m1_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_ff <= coeff_in;
      prev_ff  <= prev_in;
   end

   assign busy = (state_ff != S_IDLE);

   // The blended value is written back in S_STORE to the cell that S_FETCH read.
   `FPHS_ASSERT_SAME(a_wb_addr, clock, reset, walk_mem.we, walk_mem.waddr == $past(walk_mem.raddr, 2), "write-back address differs from fetch address")
   `FPHS_ASSERT_SAME(a_cnt_range, clock, reset, busy, (pos_ff <= side_m1_ff) && (band_ff <= side_m1_ff), "band or position counter beyond the field")
   `FPHS_ASSERT_NEXT(a_fin_hold, clock, reset, fin_req && !fin_ack, fin_req, "completion request dropped before it was taken")

endmodule

>>> rtl/four_pass_height_smoothing.sv
// Height-field smoother: a 4096-word store of signed Q16.16 heights with cell write (op 0),
// cell read (op 2) and a four-pass exponential smoothing run (op 1). Writes and reads are
// taken one per cycle while the result side keeps up; a read's data is registered in the
// store and then queued for the result side. A run on a side of n (2 to 64) walks every
// band through the single store port, reading, multiplying and writing back each cell
// after loading the band's first cell; no request is taken during the run, and it ends
// with one completion result. The store is not cleared after reset: read or smooth only
// cells that were written.
module four_pass_height_smoothing (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,  // cell_index[11:0], height_in[43:12], zero
   input  logic [fphs_pkg::OP_W-1:0]       req_tuser,  // op[1:0]
   // Response stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fphs_pkg::HEIGHT_W-1:0]   rsp_tdata,  // height_out[31:0]
   output logic                            rsp_tuser,  // result_kind[0]
   // Register writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fphs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fphs_pkg::COEFF_W-1:0]    csr_data
);
   import fphs_pkg::*;

   typedef struct packed {
      logic                kind;
      logic [HEIGHT_W-1:0] height;
   } rsp_item_type;

   logic [COEFF_W-1:0]  coeff_ff;
   logic [GRID_W-1:0]   side_ff;

   op_type              req_op;
   logic [ADDR_W-1:0]   req_index;
   logic [HEIGHT_W-1:0] req_height;
   logic                req_xfer;

   mem_req_type         host_mem;
   mem_req_type         walk_mem;
   mem_req_type         mem_req;
   logic [HEIGHT_W-1:0] rd_data;

   logic                busy;
   logic                fin_req;
   logic                fin_ack;
   logic                walk_start;

   logic                rd_pend_ff;
   logic                out_v_ff, out_v_in;
   logic                skid_v_ff, skid_v_in;
   rsp_item_type        out_ff, out_in;
   rsp_item_type        skid_ff, skid_in;
   rsp_item_type        new_item;
   logic                pop;
   logic                push;
   logic [1:0]          held;
   logic [1:0]          load;

   // Register writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_W'(32768);
         side_ff  <= GRID_W'(MAX_SIDE);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_COEFF) begin
            coeff_ff <= csr_data;
         end else if (csr_index == CSR_SIDE) begin
            side_ff <= csr_data[GRID_W-1:0];
         end
      end
   end

   // Request decode.
   assign req_op     = op_type'(req_tuser);
   assign req_index  = req_tdata[ADDR_W-1:0];
   assign req_height = req_tdata[ADDR_W +: HEIGHT_W];

   // Items still owed to the response side after this cycle's transfer.
   assign pop  = out_v_ff && rsp_tready;
   assign held = 2'(out_v_ff) + 2'(skid_v_ff) - 2'(pop);
   assign load = held + 2'(rd_pend_ff);

   assign req_tready = !busy && (load < 2'd2);
   assign req_xfer   = req_tvalid && req_tready;
   assign walk_start = req_xfer && (req_op == OP_FILTER);

   always_comb begin
      host_mem       = '0;
      host_mem.waddr = req_index;
      host_mem.wdata = req_height;
      host_mem.raddr = req_index;
      host_mem.we    = req_xfer && (req_op == OP_WRITE);
      host_mem.re    = req_xfer && (req_op == OP_READ);
   end

   assign mem_req = busy ? walk_mem : host_mem;

   fphs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fphs_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .coeff_cfg (coeff_ff),
      .side_cfg  (side_ff),
      .rd_data   (rd_data),
      .fin_ack   (fin_ack),
      .walk_mem  (walk_mem),
      .busy      (busy),
      .fin_req   (fin_req)
   );

   // The completion result waits until no read data is landing and a slot is free.
   assign fin_ack = fin_req && !rd_pend_ff && (held < 2'd2);
   assign push    = rd_pend_ff || fin_ack;

   always_comb begin
      if (rd_pend_ff) begin
         new_item.kind   = KIND_READ;
         new_item.height = rd_data;
      end else begin
         new_item.kind   = KIND_DONE;
         new_item.height = '0;
      end
   end

   // Two-entry response queue: out_ff is the head, skid_ff the entry behind it.
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_in   = new_item;
            skid_v_in = push;
         end else begin
            out_in    = new_item;
            out_v_in  = push;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff) begin
            out_in   = new_item;
            out_v_in = 1'b1;
         end else begin
            skid_in   = new_item;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         out_v_ff   <= 1'b0;
         skid_v_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= host_mem.re && !busy;
         out_v_ff   <= out_v_in;
         skid_v_ff  <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.height;
   assign rsp_tuser  = out_ff.kind;

endmodule

>>> verif/height_smoothing_checker.sv
`timescale 1ns / 100ps

module height_smoothing_checker
   import fphs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,   // cell_index[11:0], height_in[43:12], zero
   input  logic [OP_W-1:0]       req_tuser,   // op[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [HEIGHT_W-1:0]   rsp_tdata,   // height_out[31:0]
   input  logic                  rsp_tuser,   // result_kind[0]
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEFF_W-1:0]    csr_data,
   output int                    results_due,
   output int                    mismatch_count
);

   typedef struct packed {
      logic                kind;
      logic [HEIGHT_W-1:0] height;
   } height_reply_type;

   logic [HEIGHT_W-1:0] height_field [STORE_DEPTH];
   logic [COEFF_W-1:0]  coeff_k;
   logic [GRID_W-1:0]   side_n;
   height_reply_type    due_results [$];

   // Weighted blend of the new previous cell and the old current cell. The sum is
   // exact in 64 bits and the arithmetic shift floors toward minus infinity.
   function automatic logic [HEIGHT_W-1:0] blend_cell(input logic [HEIGHT_W-1:0] prev,
                                                      input logic [HEIGHT_W-1:0] cur,
                                                      input longint k);
      longint p;
      longint c;
      longint s;
      p = longint'($signed(prev));
      c = longint'($signed(cur));
      s = k * p + (longint'(65536) - k) * c;
      s = s >>> 16;
      return s[HEIGHT_W-1:0];
   endfunction

   function automatic void smooth_field();
      longint k;
      int     n;
      int     pos;
      k = (coeff_k > COEFF_ONE) ? longint'(COEFF_ONE) : longint'(coeff_k);
      n = (side_n > MAX_SIDE) ? MAX_SIDE : int'(side_n);
      if (n < 2) return;
      for (int b = 0; b < n; b++) begin
         for (int i = 1; i < n; i++) begin
            pos = b * n + i;
            height_field[pos] = blend_cell(height_field[pos - 1], height_field[pos], k);
         end
      end
      for (int b = 0; b < n; b++) begin
         for (int i = n - 2; i >= 0; i--) begin
            pos = b * n + i;
            height_field[pos] = blend_cell(height_field[pos + 1], height_field[pos], k);
         end
      end
      for (int b = 0; b < n; b++) begin
         for (int i = 1; i < n; i++) begin
            pos = i * n + b;
            height_field[pos] = blend_cell(height_field[pos - n], height_field[pos], k);
         end
      end
      for (int b = 0; b < n; b++) begin
         for (int i = n - 2; i >= 0; i--) begin
            pos = i * n + b;
            height_field[pos] = blend_cell(height_field[pos + n], height_field[pos], k);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      height_reply_type want;
      height_reply_type got;
      logic [11:0]      cell_idx;
      logic             bad;
      if (reset) begin
         coeff_k = COEFF_W'(32768);
         side_n  = GRID_W'(MAX_SIDE);
         due_results.delete();
         results_due    <= 0;
         mismatch_count <= 0;
      end else begin
         // A result never belongs to the request taken at the same edge, so the
         // comparison goes first.
         if (rsp_tvalid && rsp_tready) begin
            got = '{kind: rsp_tuser, height: rsp_tdata};
            if (due_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got kind %0d height %h",
                        $time, got.kind, got.height);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = due_results.pop_front();
               bad  = 1'b0;
               if (got.kind !== want.kind) begin
                  $display("%0t ns: result_kind mismatch, expected %0d, got %0d",
                           $time, want.kind, got.kind);
                  bad = 1'b1;
               end
               if (got.height !== want.height) begin
                  $display("%0t ns: height_out mismatch, expected %h, got %h",
                           $time, want.height, got.height);
                  bad = 1'b1;
               end
               if (bad) mismatch_count <= mismatch_count + 1;
            end
         end

         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COEFF) coeff_k = csr_data;
            else if (csr_index == CSR_SIDE) side_n = csr_data[GRID_W-1:0];
         end

         if (req_tvalid && req_tready) begin
            cell_idx = req_tdata[11:0];
            case (req_tuser)
               OP_WRITE: height_field[cell_idx] = req_tdata[43:12];
               OP_FILTER: begin
                  smooth_field();
                  due_results.push_back('{kind: KIND_DONE, height: '0});
               end
               OP_READ: due_results.push_back('{kind: KIND_READ,
                                                height: height_field[cell_idx]});
               default: ;
            endcase
         end

         results_due <= due_results.size();
      end
   end

endmodule

>>> verif/four_pass_height_smoothing_tb.sv
`timescale 1ns / 100ps

module four_pass_height_smoothing_tb;
   import fphs_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PCT     = 38;
   localparam int PHASES       = 12;
   localparam int ITEMS_PER    = 24;
   localparam int FILL_SIDE    = 16;
   localparam int SETTLE       = 16;
   localparam int QUIET_LIMIT  = 200000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata  = '0;  // cell_index[11:0], height_in[43:12], zero
   logic [OP_W-1:0]        req_tuser  = '0;  // op[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [HEIGHT_W-1:0]    rsp_tdata;        // height_out[31:0]
   logic                   rsp_tuser;        // result_kind[0]
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [COEFF_W-1:0]     csr_data   = '0;

   int   results_due;
   int   mismatch_count;
   bit   steady = 1'b0;
   int   quiet_cycles = 0;
   int   writes_sent  = 0;
   int   reads_sent   = 0;
   int   filters_sent = 0;
   int   unused_sent  = 0;
   bit   cell_written [STORE_DEPTH];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   four_pass_height_smoothing u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   height_smoothing_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .results_due    (results_due),
      .mismatch_count (mismatch_count)
   );

   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // A filter run makes no transfer while it lasts; the quiet limit outlasts a full-size run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [HEIGHT_W-1:0] any_height();
      int r;
      r = $urandom_range(99);
      if (r < 12) return 32'h7FFF_FFFF;
      if (r < 24) return 32'h8000_0000;
      return $urandom();
   endfunction

   // Leaves tvalid high after the transfer so back-to-back requests never
   // lower and raise it in the same step.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [11:0] cell_idx,
                               input logic [HEIGHT_W-1:0] height);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, height, cell_idx};
      if (op == OP_WRITE) cell_written[cell_idx] = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         OP_WRITE:  writes_sent++;
         OP_READ:   reads_sent++;
         OP_FILTER: filters_sent++;
         default:   unused_sent++;
      endcase
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [COEFF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      int               k_val;
      int               side_val;
      int               field_n;
      int               filters_here;
      int               items_here;
      int               r;
      logic [OP_W-1:0]  op;
      logic [11:0]      cell_idx;
      logic [HEIGHT_W-1:0] fill_value;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every cell of the largest field in use is written first, so later reads
      // and filter runs never touch an undefined cell. The first cells carry the
      // height extremes.
      for (int c = 0; c < FILL_SIDE * FILL_SIDE; c++) begin
         case (c)
            0:       fill_value = 32'h7FFF_FFFF;
            1:       fill_value = 32'h8000_0000;
            2:       fill_value = '0;
            3:       fill_value = 32'hFFFF_FFFF;
            default: fill_value = $urandom();
         endcase
         send_request(OP_WRITE, 12'(c), fill_value);
      end

      send_request(OP_WRITE, 12'd4095, 32'h8000_0001);
      send_request(OP_READ, 12'd0, $urandom());
      send_request(OP_READ, 12'd1, $urandom());
      send_request(OP_READ, 12'd4095, $urandom());
      send_request(OP_UNUSED, 12'($urandom()), $urandom());
      drain();
      write_register(CSR_SIDE, COEFF_W'(FILL_SIDE));
      csr_valid <= 1'b0;
      send_request(OP_FILTER, 12'($urandom()), $urandom());
      send_request(OP_READ, 12'd0, $urandom());
      send_request(OP_READ, 12'd1, $urandom());
      send_request(OP_READ, 12'd63, $urandom());
      send_request(OP_READ, 12'd64, $urandom());
      send_request(OP_READ, 12'd4095, $urandom());
      send_request(OP_WRITE, 12'd5, 32'h8000_0000);
      send_request(OP_READ, 12'd5, $urandom());
      send_request(OP_WRITE, 12'd4095, 32'h7FFF_FFFF);
      send_request(OP_READ, 12'd4095, $urandom());

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         k_val = $urandom_range(int'(COEFF_ONE));
         case (phase)
            0:       begin k_val = 0; side_val = 2; end
            1:       begin k_val = int'(COEFF_ONE); side_val = 3; end
            2:       begin k_val = 2**COEFF_W - 1; side_val = 5; end
            3:       side_val = 0;
            4:       side_val = 1;
            5:       side_val = FILL_SIDE;
            6:       side_val = $urandom_range(8, 2);
            7:       begin k_val = 1; side_val = FILL_SIDE; end
            default: side_val = $urandom_range(FILL_SIDE, 2);
         endcase
         field_n = (side_val > MAX_SIDE) ? MAX_SIDE : side_val;
         write_register(CSR_COEFF, COEFF_W'(k_val));
         write_register(CSR_SIDE, COEFF_W'(side_val));
         write_register(CSR_IDX_W'($urandom_range(2**CSR_IDX_W - 1, int'(CSR_SIDE) + 1)),
                        COEFF_W'($urandom()));
         csr_valid <= 1'b0;
         steady = (phase == 6);
         filters_here = 0;
         items_here = (phase == 6) ? 3 * ITEMS_PER : ITEMS_PER;

         for (int item = 0; item < items_here; item++) begin
            r = $urandom_range(99);
            if (r < 45) op = OP_WRITE;
            else if (r < 80) op = OP_READ;
            else if (r < 92) op = (field_n <= 16 || filters_here == 0) ? OP_FILTER : OP_READ;
            else op = OP_UNUSED;
            if (op == OP_FILTER) filters_here++;
            if (field_n >= 1 && $urandom_range(3) != 0)
               cell_idx = 12'($urandom_range(field_n * field_n - 1));
            else
               cell_idx = 12'($urandom());
            // Reads stay on cells that already hold a value.
            if (op == OP_READ && !cell_written[cell_idx])
               cell_idx = 12'($urandom_range(FILL_SIDE * FILL_SIDE - 1));
            send_request(op, cell_idx, any_height());
         end
      end
      steady = 1'b0;
      drain();

      $display("Sent %0d writes, %0d reads, %0d filter runs and %0d unused-op requests.",
               writes_sent, reads_sent, filters_sent, unused_sent);
      $display("Settings spanned sides 0 to 16 and coefficients from zero to above one.");
      if (mismatch_count == 0 && results_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results still outstanding", mismatch_count, results_due);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
